FILE: rtl/core/piecewise_linear_interpolator_unit_defines.svh
// Assertion macros for the piecewise linear interpolator.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define PLM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication
`define PLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/plm_pkg.sv
// Shared types and constants of the piecewise linear interpolator.
// No dependencies.
`default_nettype none

package plm_pkg;

  // Field widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 6;

  // Arithmetic widths: differences, product, sum
  localparam int MAG_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SUM_W  = DATA_W + 3;
  localparam int LO_W   = 17;
  localparam int HI_W   = MAG_W - LO_W;

  // Divider sequencing
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

  // Item opcodes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FETCH_YP,
    ST_FETCH_YN,
    ST_DIFF,
    ST_CALC,
    ST_SUM
  } plm_state_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL_LO,
    MD_MUL_HI,
    MD_CHECK,
    MD_DIV
  } plm_md_state_e;

  // Request into the multiply/divide unit: a * b / d on magnitudes
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [MAG_W-1:0] d;
  } plm_md_req_t;

  // Quotient and overflow flag, valid from the done pulse on
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [MAG_W-1:0] quo;
  } plm_md_resp_t;

endpackage

`default_nettype wire

FILE: rtl/core/plm_if.sv
// Item channels of the piecewise linear interpolator (valid/ready).
// Depends on plm_pkg.
`default_nettype none

interface plm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic        [plm_pkg::IDX_W-1:0]    point_index;
  logic signed [plm_pkg::DATA_W-1:0]   point_x;
  logic signed [plm_pkg::DATA_W-1:0]   point_y;
  logic signed [plm_pkg::DATA_W-1:0]   query_x;

  modport source (output valid, action, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink   (input valid, action, point_index, point_x, point_y, query_x,
                  output ready);
endinterface

interface plm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plm_pkg::DATA_W-1:0]   value;
  logic                                out_of_range;
  logic                                degenerate_segment;

  modport source (output valid, value, out_of_range, degenerate_segment,
                  input ready);
  modport sink   (input valid, value, out_of_range, degenerate_segment,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/piecewise_linear_interpolator_unit.sv
// Piecewise linear interpolator over a table of up to MAX_POINTS breakpoints
// (signed fixed point, FRAC_BITS fraction bits). Uses plm_pkg, plm_if,
// plm_table and plm_muldiv. A load item writes one breakpoint into the
// table and gives no result. A query item walks the abscissa memory one
// entry per cycle (n entries, n = the point count register clamped to
// 2..MAX_POINTS), tracking min/max and the first bracketing segment (else
// the last one), reads the two ordinates of that segment, then the
// multiply/divide unit forms (q - xp) * (yn - yp) / (xn - xp) in a low and a
// high multiply step, a range check and a restoring divide. A segment with
// equal x ends skips the unit and gives yp; a quotient that fails the range
// check stops the unit after the check, and the result saturates. One query
// is in flight at a time, while the finished result waits in an output
// register so the next item can be taken.
`default_nettype none

module piecewise_linear_interpolator_unit #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  plm_in_if.sink                     in_i,
  plm_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [plm_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int DW    = plm_pkg::DATA_W;
  localparam int MAG_W = plm_pkg::MAG_W;
  localparam int SUM_W = plm_pkg::SUM_W;
  localparam int AW    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int NW    = (AW + 1 > plm_pkg::CFG_W) ? AW + 1 : plm_pkg::CFG_W;

  // Largest positive product of raw differences still counted as bracketing
  localparam longint unsigned BRACKET_LIMIT =
    ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd10000000000;
  localparam int LW  = (BRACKET_LIMIT > 0) ? $clog2(BRACKET_LIMIT + 1) : 1;
  localparam int BPW = 2 * LW;

  plm_pkg::plm_state_e state_q, state_d;

  // Configuration
  logic [plm_pkg::CFG_W-1:0] points_q;
  logic [NW-1:0]             n_raw, n_eff;

  // Query context
  logic signed [DW-1:0] q_q;
  logic [AW-1:0]        n_last_q, cnt_q, j_q;
  logic signed [DW-1:0] prev_q, xmin_q, xmax_q, xp_q, xn_q, yp_q;
  logic                 found_q;
  logic                 neg_q, degen_q, start_q;
  logic [MAG_W-1:0]     dq_mag_q, dy_mag_q, dx_mag_q;

  // Output register
  logic                 out_valid_q;
  logic signed [DW-1:0] value_q;
  logic                 oor_q, dgn_q;

  // Table ports
  logic                 mem_we;
  logic [AW-1:0]        waddr, raddr;
  logic [DW-1:0]        rx, ry;

  // Walk datapath
  logic signed [DW-1:0]    x_cur;
  logic signed [MAG_W-1:0] d0, d1;
  logic [MAG_W-1:0]        m0, m1;
  logic [BPW-1:0]          bprod;
  logic                    brk;

  // Segment differences
  logic signed [MAG_W-1:0] dq, dy, dx;

  // Result
  logic signed [SUM_W-1:0] yp_w, t_w, sum_w;
  logic signed [DW-1:0]    res;
  logic                    slot_free;
  logic                    accept, accept_load, accept_query;

  plm_pkg::plm_md_req_t  md_req;
  plm_pkg::plm_md_resp_t md_resp;

  assign accept       = in_i.valid && in_i.ready;
  assign accept_load  = accept && (in_i.action == plm_pkg::ACT_LOAD);
  assign accept_query = accept && (in_i.action == plm_pkg::ACT_QUERY);
  assign slot_free    = !out_valid_q || out_o.ready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= plm_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      points_q <= cfg_data_i;
    end
  end

  // Clamp point count to 2..MAX_POINTS
  assign n_raw = NW'(points_q);
  assign n_eff = (n_raw < NW'(2))          ? NW'(2) :
                 (n_raw > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : n_raw;

  // Table
  assign mem_we = accept_load && (32'(in_i.point_index) < MAX_POINTS);
  assign waddr  = AW'(in_i.point_index);

  plm_table #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wx_i    (in_i.point_x),
    .wy_i    (in_i.point_y),
    .raddr_i (raddr),
    .rx_o    (rx),
    .ry_o    (ry)
  );

  // Bracketing test of segment (prev, current) against the query
  assign x_cur = rx;
  assign d0    = {q_q[DW-1], q_q} - {prev_q[DW-1], prev_q};
  assign d1    = {q_q[DW-1], q_q} - {x_cur[DW-1], x_cur};
  assign m0    = d0[MAG_W-1] ? MAG_W'(-d0) : MAG_W'(d0);
  assign m1    = d1[MAG_W-1] ? MAG_W'(-d1) : MAG_W'(d1);
  assign bprod = m0[LW-1:0] * m1[LW-1:0];
  assign brk   = (d0 == '0) || (d1 == '0) || (d0[MAG_W-1] != d1[MAG_W-1]) ||
                 ((m0 <= MAG_W'(BRACKET_LIMIT)) && (m1 <= MAG_W'(BRACKET_LIMIT)) &&
                  (bprod <= BPW'(BRACKET_LIMIT)));

  // Differences of the chosen segment; ry holds yn in ST_DIFF
  assign dq = {q_q[DW-1], q_q}   - {xp_q[DW-1], xp_q};
  assign dy = {ry[DW-1], ry}     - {yp_q[DW-1], yp_q};
  assign dx = {xn_q[DW-1], xn_q} - {xp_q[DW-1], xp_q};

  // Control: next state, ready and read address
  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    raddr      = '0;
    case (state_q)
      plm_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (accept_query) state_d = plm_pkg::ST_WALK;
      end
      plm_pkg::ST_WALK: begin
        if (cnt_q == n_last_q) begin
          raddr   = cnt_q;
          state_d = plm_pkg::ST_FETCH_YP;
        end else begin
          raddr = cnt_q + 1'b1;
        end
      end
      plm_pkg::ST_FETCH_YP: begin
        raddr   = j_q;
        state_d = plm_pkg::ST_FETCH_YN;
      end
      plm_pkg::ST_FETCH_YN: begin
        raddr   = j_q + 1'b1;
        state_d = plm_pkg::ST_DIFF;
      end
      plm_pkg::ST_DIFF: state_d = plm_pkg::ST_CALC;
      plm_pkg::ST_CALC: begin
        if (degen_q || md_resp.done) state_d = plm_pkg::ST_SUM;
      end
      plm_pkg::ST_SUM: begin
        if (slot_free) state_d = plm_pkg::ST_IDLE;
      end
      default: state_d = plm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plm_pkg::ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (state_q == plm_pkg::ST_DIFF) && (xn_q != xp_q);
    end
  end

  // Query datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      plm_pkg::ST_IDLE: begin
        if (accept_query) begin
          q_q      <= in_i.query_x;
          n_last_q <= AW'(n_eff - NW'(1));
          cnt_q    <= '0;
          found_q  <= 1'b0;
        end
      end
      plm_pkg::ST_WALK: begin
        if (cnt_q == '0) begin
          xmin_q <= x_cur;
          xmax_q <= x_cur;
        end else begin
          if (x_cur < xmin_q) xmin_q <= x_cur;
          if (x_cur > xmax_q) xmax_q <= x_cur;
          // first bracketing segment, else the last one
          if (!found_q && (brk || cnt_q == n_last_q)) begin
            found_q <= 1'b1;
            j_q     <= cnt_q - 1'b1;
            xp_q    <= prev_q;
            xn_q    <= x_cur;
          end
        end
        prev_q <= x_cur;
        cnt_q  <= cnt_q + 1'b1;
      end
      plm_pkg::ST_FETCH_YN: yp_q <= ry;
      plm_pkg::ST_DIFF: begin
        degen_q  <= xn_q == xp_q;
        neg_q    <= dq[MAG_W-1] ^ dy[MAG_W-1] ^ dx[MAG_W-1];
        dq_mag_q <= dq[MAG_W-1] ? MAG_W'(-dq) : MAG_W'(dq);
        dy_mag_q <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        dx_mag_q <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      end
      default: ;
    endcase
  end

  assign md_req.start = start_q;
  assign md_req.a     = dq_mag_q;
  assign md_req.b     = dy_mag_q;
  assign md_req.d     = dx_mag_q;

  plm_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .resp_o (md_resp)
  );

  // yp plus signed quotient, saturated to 32 bits; yp alone for equal x ends
  assign yp_w  = {{(SUM_W - DW){yp_q[DW-1]}}, yp_q};
  assign t_w   = {{(SUM_W - MAG_W){1'b0}}, md_resp.quo};
  assign sum_w = neg_q ? (yp_w - t_w) : (yp_w + t_w);

  always_comb begin
    if (degen_q) begin
      res = yp_q;
    end else if (md_resp.ovf) begin
      res = neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (sum_w[SUM_W-1:DW-1] != {(SUM_W-DW+1){sum_w[SUM_W-1]}}) begin
      res = sum_w[SUM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      res = sum_w[DW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == plm_pkg::ST_SUM && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == plm_pkg::ST_SUM && slot_free) begin
      value_q <= res;
      oor_q   <= (q_q < xmin_q) || (q_q > xmax_q);
      dgn_q   <= degen_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.value              = value_q;
  assign out_o.out_of_range       = oor_q;
  assign out_o.degenerate_segment = dgn_q;

endmodule

`default_nettype wire

FILE: rtl/core/plm_table.sv
// Breakpoint table: abscissa and ordinate memories, one write and one
// registered read address shared by both. Depends on plm_pkg.
`default_nettype none

module plm_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [plm_pkg::DATA_W-1:0] wx_i,
  input  logic [plm_pkg::DATA_W-1:0] wy_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [plm_pkg::DATA_W-1:0] rx_o,
  output logic [plm_pkg::DATA_W-1:0] ry_o
);

  logic [plm_pkg::DATA_W-1:0] mem_x [DEPTH];
  logic [plm_pkg::DATA_W-1:0] mem_y [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rx_o <= mem_x[raddr_i];
    ry_o <= mem_y[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/plm_muldiv.sv
// Multiply/divide unit: a * b / d on unsigned magnitudes, product in two
// halves on one shared multiplier, then restoring division one bit a cycle.
// Depends on plm_pkg.
`default_nettype none

module plm_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  plm_pkg::plm_md_req_t  req_i,
  output plm_pkg::plm_md_resp_t resp_o
);

  localparam int MAG_W  = plm_pkg::MAG_W;
  localparam int PROD_W = plm_pkg::PROD_W;
  localparam int LO_W   = plm_pkg::LO_W;

  plm_pkg::plm_md_state_e state_q, state_d;

  logic [MAG_W-1:0]              a_q, b_q, d_q;
  logic [PROD_W-1:0]             prod_q;
  logic [MAG_W-1:0]              rem_q;
  logic [MAG_W-1:0]              quo_q;
  logic [plm_pkg::STEP_W-1:0]    step_q;
  logic                          ovf_q;
  logic                          done_q, done_d;

  logic [LO_W-1:0]               mul_b;
  logic [MAG_W+LO_W-1:0]         pp;
  logic                          ovf_now;
  logic [MAG_W:0]                trial;
  logic                          fits;
  logic                          last_step;

  // Shared multiplier: low half of b first, high half next
  assign mul_b = (state_q == plm_pkg::MD_MUL_LO) ? b_q[LO_W-1:0]
                                                 : LO_W'(b_q[MAG_W-1:LO_W]);
  assign pp    = a_q * mul_b;

  // Quotient needs more than MAG_W bits
  assign ovf_now   = prod_q >= PROD_W'({d_q, {MAG_W{1'b0}}});
  assign trial     = {rem_q, quo_q[MAG_W-1]};
  assign fits      = trial >= {1'b0, d_q};
  assign last_step = step_q == plm_pkg::STEP_W'(plm_pkg::DIV_STEPS - 1);

  // Sequencer
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      plm_pkg::MD_IDLE: begin
        if (req_i.start) state_d = plm_pkg::MD_MUL_LO;
      end
      plm_pkg::MD_MUL_LO: state_d = plm_pkg::MD_MUL_HI;
      plm_pkg::MD_MUL_HI: state_d = plm_pkg::MD_CHECK;
      plm_pkg::MD_CHECK: begin
        if (ovf_now) begin
          state_d = plm_pkg::MD_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = plm_pkg::MD_DIV;
        end
      end
      plm_pkg::MD_DIV: begin
        if (last_step) begin
          state_d = plm_pkg::MD_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = plm_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plm_pkg::MD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      plm_pkg::MD_IDLE: begin
        if (req_i.start) begin
          a_q <= req_i.a;
          b_q <= req_i.b;
          d_q <= req_i.d;
        end
      end
      plm_pkg::MD_MUL_LO: prod_q <= PROD_W'(pp);
      plm_pkg::MD_MUL_HI: prod_q <= prod_q + (PROD_W'(pp) << LO_W);
      plm_pkg::MD_CHECK: begin
        ovf_q  <= ovf_now;
        rem_q  <= prod_q[PROD_W-1:MAG_W];
        quo_q  <= prod_q[MAG_W-1:0];
        step_q <= '0;
      end
      plm_pkg::MD_DIV: begin
        rem_q  <= fits ? MAG_W'(trial - {1'b0, d_q}) : MAG_W'(trial);
        quo_q  <= {quo_q[MAG_W-2:0], fits};
        step_q <= step_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign resp_o.done = done_q;
  assign resp_o.ovf  = ovf_q;
  assign resp_o.quo  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/plm_sva.sv
// Port-level assertions for the piecewise linear interpolator, bound to
// the top level. Depends on plm_pkg and the assertion macro header.
`default_nettype none
`include "piecewise_linear_interpolator_unit_defines.svh"

module plm_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [plm_pkg::DATA_W-1:0]    out_value,
  input logic                          out_oor,
  input logic                          out_degen
);

  logic query_acc, load_acc;

  assign query_acc = in_valid && in_ready && (in_action == plm_pkg::ACT_QUERY);
  assign load_acc  = in_valid && in_ready && (in_action == plm_pkg::ACT_LOAD);

  // A query occupies the block for at least the next cycle
  `PLM_ASSERT_NEXT(a_query_busy, query_acc, !in_ready)

  // After a load the block is ready again in the next cycle
  `PLM_ASSERT_NEXT(a_load_single, load_acc, in_ready)

  // A new item appears only when a query was finishing
  `PLM_ASSERT_IMPL(a_result_from_query, $rose(out_valid), $past(!in_ready))

  // A stalled item holds
  `PLM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_value) && $stable(out_oor) && $stable(out_degen))

endmodule

bind piecewise_linear_interpolator_unit plm_sva u_plm_sva (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_action (in_i.action),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_value (out_o.value),
  .out_oor   (out_o.out_of_range),
  .out_degen (out_o.degenerate_segment)
);

`default_nettype wire

FILE: tb/piecewise_linear_interpolator_unit_tb.sv
// Self-checking testbench for the piecewise linear interpolator unit.
// Depends on plm_pkg, plm_if and the unit itself. Breakpoint tables are loaded
// at several point counts, queried, and every result is checked in order.
`default_nettype none

module piecewise_linear_interpolator_unit_tb;

  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;
  localparam int CLK_PERIOD = 12;
  localparam int DATA_W     = plm_pkg::DATA_W;
  localparam int IDX_W      = plm_pkg::IDX_W;
  localparam int CFG_W      = plm_pkg::CFG_W;
  // Idle time before each phase and after the last result
  localparam int SETTLE_CYCLES    = 160;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int MAX_REPORTS      = 40;

  localparam logic signed [DATA_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;

  typedef struct {
    logic                     action;
    logic [IDX_W-1:0]         point_index;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] query_x;
  } plm_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     out_of_range;
    logic                     degenerate_segment;
  } plm_result_t;

  // Breakpoint table copy, point count and the queue of awaited results
  class interp_scoreboard;
    logic signed [DATA_W-1:0] xs[MAX_POINTS];
    logic signed [DATA_W-1:0] ys[MAX_POINTS];
    logic [CFG_W-1:0]         point_count;
    plm_result_t              awaited[$];
    bit                       last_saturated;
    int mismatches, n_loads, n_queries, n_degen, n_outside, n_saturated;

    function new();
      point_count = plm_pkg::CFG_RESET;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_point_count(logic [CFG_W-1:0] v);
      point_count = v;
    endfunction

    // Register value clamped to 2..MAX_POINTS
    function int span_points();
      if (point_count < 2) return 2;
      if (point_count > MAX_POINTS) return MAX_POINTS;
      return int'(point_count);
    endfunction

    function logic signed [DATA_W-1:0] clamp32(longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v[DATA_W-1:0];
    endfunction

    function int sign_of(longint v);
      return int'(v > 0) - int'(v < 0);
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    // Segment brackets q when (q - a) * (q - b) stays under 1e-10 in real
    // units; at 16 fraction bits that threshold truncates to zero
    function bit straddles(longint q, longint a, longint b);
      longint unsigned limit;
      int s0, s1;
      limit = ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd10000000000;
      s0 = sign_of(q - a);
      s1 = sign_of(q - b);
      if (s0 == 0 || s1 == 0 || s0 != s1) return 1'b1;
      return (magnitude(q - a) * magnitude(q - b)) <= limit;
    endfunction

    function plm_result_t interpolate(logic signed [DATA_W-1:0] q_raw);
      plm_result_t r;
      int n, seg, s;
      longint q, xmin, xmax, xp, xn, yp, yn, dq, dy, dx, res;
      longint unsigned quo;
      n = span_points();
      q = q_raw;
      xmin = xs[0];
      xmax = xmin;
      for (int i = 1; i < n; i++) begin
        if (longint'(xs[i]) < xmin) xmin = xs[i];
        if (longint'(xs[i]) > xmax) xmax = xs[i];
      end
      // First bracketing segment, else the last one (extrapolation)
      seg = n - 2;
      for (int i = 0; i + 1 < n; i++) begin
        if (straddles(q, xs[i], xs[i+1])) begin
          seg = i;
          break;
        end
      end
      xp = xs[seg];
      xn = xs[seg+1];
      yp = ys[seg];
      yn = ys[seg+1];
      r.out_of_range       = (q < xmin) || (q > xmax);
      r.degenerate_segment = (xn == xp);
      last_saturated       = 1'b0;
      if (xn == xp) begin
        res = yp;
      end else begin
        dq = q - xp;
        dy = yn - yp;
        dx = xn - xp;
        s = sign_of(dq) * sign_of(dy) * sign_of(dx);
        quo = (magnitude(dq) * magnitude(dy)) / magnitude(dx);
        if (quo >= (64'd1 << 33))
          res = (s < 0) ? longint'(Q_MIN) - 1 : longint'(Q_MAX) + 1;
        else
          res = yp + ((s < 0) ? -longint'(quo) : longint'(quo));
      end
      last_saturated = (res > longint'(Q_MAX)) || (res < longint'(Q_MIN));
      r.value = clamp32(res);
      return r;
    endfunction

    // Accepted input item: loads update the table, queries queue a result
    function void note_item(plm_item_t it);
      plm_result_t r;
      if (it.action == plm_pkg::ACT_LOAD) begin
        n_loads++;
        if (int'(it.point_index) < MAX_POINTS) begin
          xs[it.point_index] = it.point_x;
          ys[it.point_index] = it.point_y;
        end
      end else begin
        n_queries++;
        r = interpolate(it.query_x);
        if (r.degenerate_segment) n_degen++;
        if (r.out_of_range) n_outside++;
        if (last_saturated) n_saturated++;
        awaited = {awaited, r};
      end
    endfunction

    function void report(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                 $time, what, want, want[31:0], got, got[31:0]);
    endfunction

    // Accepted result: compare with the oldest awaited one
    function void check_result(plm_result_t got);
      plm_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing awaited: value %0d range %0b degenerate %0b",
                 $time, got.value, got.out_of_range, got.degenerate_segment);
        return;
      end
      want = awaited.pop_front();
      if (got.value !== want.value) report("value", want.value, got.value);
      if (got.out_of_range !== want.out_of_range)
        report("out_of_range", want.out_of_range, got.out_of_range);
      if (got.degenerate_segment !== want.degenerate_segment)
        report("degenerate_segment", want.degenerate_segment, got.degenerate_segment);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_data_i;

  plm_in_if  in_if ();
  plm_out_if out_if ();

  interp_scoreboard sb = new();

  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_cycles;
  int active_points;
  int settings_run;

  piecewise_linear_interpolator_unit #(
    .MAX_POINTS(MAX_POINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(CLK_PERIOD * 3000000);
    $display("piecewise_linear_interpolator_unit_tb: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles = 0;
        repeat (HOLD_OFF_CYCLES) begin
          out_if.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    plm_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.value              = out_if.value;
      got.out_of_range       = out_if.out_of_range;
      got.degenerate_segment = out_if.degenerate_segment;
      sb.check_result(got);
    end
  end

  // Offer one item, with random idle cycles first, until accepted
  task automatic send_item(input plm_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= it.action;
    in_if.point_index <= it.point_index;
    in_if.point_x     <= it.point_x;
    in_if.point_y     <= it.point_y;
    in_if.query_x     <= it.query_x;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic load_point(input int idx, input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] y);
    plm_item_t it;
    it.action      = plm_pkg::ACT_LOAD;
    it.point_index = idx[IDX_W-1:0];
    it.point_x     = x;
    it.point_y     = y;
    it.query_x     = $urandom;
    send_item(it);
  endtask

  task automatic query_at(input logic signed [DATA_W-1:0] q);
    plm_item_t it;
    it.action      = plm_pkg::ACT_QUERY;
    it.point_index = $urandom;
    it.point_x     = $urandom;
    it.point_y     = $urandom;
    it.query_x     = q;
    send_item(it);
  endtask

  // Sender pause until every awaited result is back
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_points_reg(input logic [CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_point_count(v);
    cfg_we_i <= 1'b0;
    active_points = sb.span_points();
    settings_run++;
  endtask

  // Fill entries 0..count-1; most shapes are ordered tables
  task automatic load_breakpoints(input int count, input int shape);
    longint base, step, x, y;
    base = longint'($signed($urandom)) / 2;
    step = $urandom_range(32'h0100_0000, 1);
    x = -longint'(count) * 32'h0002_0000;
    for (int i = 0; i < count; i++) begin
      y = longint'($signed($urandom)) >>> 3;
      case (shape)
        0: x = base + i * step;
        1: x = base - i * step;
        2: begin
          x = longint'($signed($urandom));
          y = longint'($signed($urandom));
        end
        3: begin
          // unit grid with repeated abscissas
          if (i > 0 && $urandom_range(3) != 0) x = x + 32'h0001_0000 * $urandom_range(4, 1);
          y = longint'($signed($urandom)) >>> 12;
        end
        default: begin
          // spans the whole range, full-scale ordinates
          x = longint'(Q_MIN) + i * ((64'd1 << 32) / count);
          y = longint'($signed($urandom));
        end
      endcase
      load_point(i, sb.clamp32(x), sb.clamp32(y));
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_query();
    int i;
    longint lo, hi, span;
    i = $urandom_range(active_points - 2);
    lo = sb.xs[i];
    hi = sb.xs[i+1];
    if (lo > hi) begin
      span = lo;
      lo = hi;
      hi = span;
    end
    span = hi - lo;
    case ($urandom_range(9))
      0, 1, 2, 3: return sb.clamp32(lo + (longint'($urandom) % (span + 1)));
      4: return sb.xs[$urandom_range(active_points - 1)];
      5: return sb.clamp32(longint'(sb.xs[i]) + $signed($urandom_range(6)) - 3);
      6: begin
        case ($urandom_range(3))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    int idx;
    logic signed [DATA_W-1:0] x;
    if ($urandom_range(99) < 20) begin
      idx = $urandom_range(MAX_POINTS - 1);
      // in-use entries mostly keep their abscissa so the table stays ordered
      if (idx < active_points && $urandom_range(3) != 0) x = sb.xs[idx];
      else x = $urandom;
      load_point(idx, x, $urandom);
    end else begin
      query_at(pick_query());
    end
  endtask

  // Main sequence
  initial begin : stimulus
    logic [CFG_W-1:0] plan[12];
    plan = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd65, 7'd5, 7'd33, 7'd3, 7'd64, 7'd17, 7'd2, 7'd48};
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    rx_hold_cycles    = 0;
    settings_run      = 0;
    active_points     = 2;
    rst_ni            = 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_data_i        <= '0;
    in_if.valid       <= 1'b0;
    in_if.action      <= plm_pkg::ACT_LOAD;
    in_if.point_index <= '0;
    in_if.point_x     <= '0;
    in_if.point_y     <= '0;
    in_if.query_x     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_points_reg(plm_pkg::CFG_RESET);

    // Directed: full-range segment, crossing both extremes
    load_point(0, Q_MIN, Q_MAX);
    load_point(1, Q_MAX, Q_MIN);
    query_at(Q_MIN);
    query_at(Q_MAX);
    query_at(0);
    query_at(-1);
    // steep unit segment: saturation both ways
    load_point(1, 1, Q_MAX);
    load_point(0, 0, 0);
    query_at(Q_MAX);
    query_at(Q_MIN);
    query_at(1);
    // equal x ends, inside and outside the table
    load_point(1, 0, 5);
    query_at(0);
    query_at(100);
    // negative slope in Q16.16, interpolated and extrapolated
    load_point(0, 32'h0001_0000, 32'h0002_0000);
    load_point(1, 32'h0003_0000, 32'hfffc_0000);
    query_at(32'h0002_0000);
    query_at(32'h0005_0000);
    query_at(32'hffff_0000);
    query_at(32'h0001_0001);
    load_point(MAX_POINTS - 1, Q_MAX, Q_MIN);

    // Random phases over several point counts and idling patterns
    foreach (plan[p]) begin
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      write_points_reg(plan[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      load_breakpoints(active_points, p % 5);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (p % 3 == 1 && k == 30) rx_hold_cycles = 1;
        if (k == 70) wait_results_drained();
        send_random_item();
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d loads and %0d queries over %0d point-count settings.",
             sb.n_loads, sb.n_queries, settings_run);
    $display("Queries hit %0d degenerate segments, %0d out of range, %0d saturated.",
             sb.n_degen, sb.n_outside, sb.n_saturated);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("piecewise_linear_interpolator_unit_tb: PASS");
    else
      $display("piecewise_linear_interpolator_unit_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
